// ===== rtl/core/vfc_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vfc_pkg - shared types and constants of the voxel face culling block
// Stream field widths, neighborhood tables and state encoding.
// ============================================================================
package vfc_pkg;

    // Stream payload layout
    localparam int POS_X_W       = 5;
    localparam int POS_Y_W       = 7;
    localparam int POS_Z_W       = 5;
    localparam int BLOCK_INDEX_W = 14;
    localparam int FACE_MASK_W   = 6;
    localparam int FACE_COUNT_W  = 3;
    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 24;

    // Action codes carried on tuser
    localparam logic ACT_PLACE   = 1'b0;
    localparam logic ACT_DESTROY = 1'b1;

    // Faces: +y, -y, +x, -x, +z, -z
    localparam int NB_FACES = 6;
    localparam int FACE_DX [NB_FACES] = '{0, 0, 1, -1, 0, 0};
    localparam int FACE_DY [NB_FACES] = '{1, -1, 0, 0, 0, 0};
    localparam int FACE_DZ [NB_FACES] = '{0, 0, 0, 0, 1, -1};

    // Rows (y,z) around the target that hold every cell the masks look at.
    // Slot 0 is the target row itself.
    localparam int NB_SLOTS = 13;
    localparam int SLOT_DY [NB_SLOTS] = '{0, 1, -1, 0, 0, 2, -2, 0, 0, 1, 1, -1, -1};
    localparam int SLOT_DZ [NB_SLOTS] = '{0, 0, 0, 1, -1, 0, 0, 2, -2, 1, -1, 1, -1};
    localparam int SLOT_W   = 4;
    localparam int SLICE_W  = 5;   // bits x-2 .. x+2 of a row

    // Cells reported per edit: target plus six neighbors
    localparam int NB_CELLS = 7;
    localparam int CELL_W   = 3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_DRAIN,
        ST_CALC,
        ST_EMIT
    } t_state;

    function automatic int slot_of(int dy, int dz);
        int s;
        s = 0;
        for (int i = 0; i < NB_SLOTS; i++) begin
            if (SLOT_DY[i] == dy && SLOT_DZ[i] == dz) begin
                s = i;
            end
        end
        return s;
    endfunction

    // Offset of reported cell c: 0 is the target, c>0 is neighbor face c-1
    function automatic int cell_dx(int c);
        return (c == 0) ? 0 : FACE_DX[c-1];
    endfunction

    function automatic int cell_dy(int c);
        return (c == 0) ? 0 : FACE_DY[c-1];
    endfunction

    function automatic int cell_dz(int c);
        return (c == 0) ? 0 : FACE_DZ[c-1];
    endfunction

endpackage

// ===== rtl/core/voxel_face_culling.sv =====
`timescale 1ns / 1ps
// ============================================================================
// voxel_face_culling - hidden-face culling over one voxel chunk
// Keeps the chunk occupancy in a row memory and reports exposed-face masks
// for every block whose visibility changes on a place or destroy request.
// ============================================================================
// Timing: the first result is registered after the accept, the 13 row reads
//   and the drain and mask-calc states, once the list walk reaches the first
//   present slot, so a place with no neighbors waits longest.
// Flow: accept, 13 row reads, drain, mask calc, then the 7 list slots, one
//   per cycle when the output is not stalled; a destroy stops at its last
//   present slot. tready is high only in idle: a new request waits for the
//   last result of the one before. Out-of-chunk requests are dropped.
// Reset: synchronous, active low. A clearing pass then writes WIDTH*HEIGHT
//   rows with tready low before requests flow.
// ============================================================================
//
// Organization
//   The occupancy map is stored as rows along x: row address y + HEIGHT*z,
//   WIDTH bits per row. One row read gives the target and its x neighbors.
//   Every mask needed for one edit looks at cells within a diamond-shaped yz
//   distance of two, so 13 row reads fill a window of 5-bit slices
//   (x-2..x+2). Cells outside the chunk land as zeros, which makes their
//   faces exposed with no extra checks.
//   The target row comes back first; it is written back with the edited bit
//   while the remaining rows stream in (different rows, so no hazard), and
//   the window copy of the target is taken from the edited row.
//   The 7 masks are then computed combinationally from fixed window bits and
//   put in report order: neighbors then target for a place, target (mask 0)
//   then neighbors for a destroy. Absent neighbors are skipped.
//   An output register separates the result stream from the sequencer.
//
module voxel_face_culling
    import vfc_pkg::*;
#(
    parameter int WIDTH  = 16,
    parameter int HEIGHT = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // pos_x[4:0], pos_y[11:5], pos_z[16:12]
    input  logic                 i_s_axis_tuser,  // action: 0 place, 1 destroy
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,  // block_index[13:0], face_mask[19:14],
                                                  // face_count[22:20]
    output logic                 o_m_axis_tlast   // last result of the request
);

    localparam int ROWS  = WIDTH * HEIGHT;
    localparam int RAW   = $clog2(ROWS);
    localparam int CELLS = ROWS * WIDTH;
    localparam int IDXW  = $clog2(CELLS);
    localparam int IDXE  = (IDXW > BLOCK_INDEX_W) ? IDXW : BLOCK_INDEX_W;
    localparam int WIDEW = WIDTH + 4;

    // ------------------------------------------------------------------
    // Request fields
    // ------------------------------------------------------------------
    logic [POS_X_W-1:0] s_px;
    logic [POS_Y_W-1:0] s_py;
    logic [POS_Z_W-1:0] s_pz;
    logic               s_in_chunk;

    assign s_px = i_s_axis_tdata[POS_X_W-1:0];
    assign s_py = i_s_axis_tdata[POS_X_W+POS_Y_W-1:POS_X_W];
    assign s_pz = i_s_axis_tdata[POS_X_W+POS_Y_W+POS_Z_W-1:POS_X_W+POS_Y_W];

    assign s_in_chunk = (s_px != '0) && ({1'b0, s_px} <= (POS_X_W+1)'(WIDTH))
                     && (s_py != '0) && ({1'b0, s_py} <= (POS_Y_W+1)'(HEIGHT))
                     && (s_pz != '0) && ({1'b0, s_pz} <= (POS_Z_W+1)'(WIDTH));

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [RAW-1:0]     r_clr;
    logic               r_act;
    logic [POS_X_W-1:0] r_x;
    logic [POS_Y_W-1:0] r_y;
    logic [POS_Z_W-1:0] r_z;
    logic [RAW-1:0]     r_row;
    logic [SLOT_W-1:0]  r_k;

    // read return pipeline
    logic               r_rd_vld;
    logic [SLOT_W-1:0]  r_rd_slot;
    logic               r_rd_inr;

    logic [SLICE_W-1:0] r_win [NB_SLOTS];

    // report list
    logic [CELL_W-1:0]        r_p;
    logic [NB_CELLS-1:0]      r_present;
    logic [BLOCK_INDEX_W-1:0] r_lidx  [NB_CELLS];
    logic [FACE_MASK_W-1:0]   r_lmask [NB_CELLS];
    logic [FACE_COUNT_W-1:0]  r_lcnt  [NB_CELLS];

    // output stage
    logic                     r_ov;
    logic [BLOCK_INDEX_W-1:0] r_o_idx;
    logic [FACE_MASK_W-1:0]   r_o_mask;
    logic [FACE_COUNT_W-1:0]  r_o_cnt;
    logic                     r_o_last;

    // ------------------------------------------------------------------
    // Occupancy memory
    // ------------------------------------------------------------------
    logic             ram_we;
    logic [RAW-1:0]   ram_waddr;
    logic [WIDTH-1:0] ram_wdata;
    logic             ram_re;
    logic [RAW-1:0]   ram_raddr;
    logic [WIDTH-1:0] ram_rdata;

    vfc_ram #(
        .DW    (WIDTH),
        .DEPTH (ROWS)
    ) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Row address of the slot being read
    // ------------------------------------------------------------------
    logic signed [POS_Y_W+1:0] rd_ry;
    logic signed [POS_Z_W+1:0] rd_rz;
    logic                      rd_inr;
    logic [RAW-1:0]            rd_row;

    always_comb begin
        rd_ry  = $signed({2'b00, r_y}) + (POS_Y_W+2)'(SLOT_DY[r_k]);
        rd_rz  = $signed({2'b00, r_z}) + (POS_Z_W+2)'(SLOT_DZ[r_k]);
        rd_inr = (rd_ry >= 0) && (rd_ry < (POS_Y_W+2)'(HEIGHT))
              && (rd_rz >= 0) && (rd_rz < (POS_Z_W+2)'(WIDTH));
        rd_row = RAW'(rd_ry[POS_Y_W-1:0])
               + RAW'(HEIGHT) * RAW'(rd_rz[POS_Z_W-1:0]);
    end

    // Returned row: edited copy for write-back, padded copy for slicing
    logic [WIDTH-1:0] wb_row;
    logic [WIDEW-1:0] rd_wide;
    logic             new_bit;

    assign new_bit = (r_act == ACT_PLACE);
    // target row is sliced from the edited copy
    assign rd_wide = (r_rd_slot == '0) ? {2'b00, wb_row, 2'b00}
                                       : {2'b00, ram_rdata, 2'b00};

    always_comb begin
        for (int i = 0; i < WIDTH; i++) begin
            wb_row[i] = (POS_X_W'(i) == r_x) ? new_bit : ram_rdata[i];
        end
    end

    // ------------------------------------------------------------------
    // Mask calculation over the window, then report order
    // ------------------------------------------------------------------
    logic [IDXE-1:0]         tgt_idx;
    logic [FACE_MASK_W-1:0]  c_mask  [NB_CELLS];
    logic [FACE_COUNT_W-1:0] c_cnt   [NB_CELLS];
    logic [IDXE-1:0]         c_idx   [NB_CELLS];
    logic [NB_CELLS-1:0]     c_pres;
    logic [BLOCK_INDEX_W-1:0] l_idx  [NB_CELLS];
    logic [FACE_MASK_W-1:0]   l_mask [NB_CELLS];
    logic [FACE_COUNT_W-1:0]  l_cnt  [NB_CELLS];
    logic [NB_CELLS-1:0]      l_pres;

    assign tgt_idx = IDXE'(r_x) + IDXE'(WIDTH) * IDXE'(r_row);

    always_comb begin
        for (int c = 0; c < NB_CELLS; c++) begin
            for (int g = 0; g < NB_FACES; g++) begin
                c_mask[c][g] = ~r_win[SLOT_W'(slot_of(cell_dy(c) + FACE_DY[g],
                                                     cell_dz(c) + FACE_DZ[g]))]
                                     [3'(cell_dx(c) + FACE_DX[g] + 2)];
            end
            if (c == 0 && r_act == ACT_DESTROY) begin
                c_mask[c] = '0;
            end
            c_cnt[c] = '0;
            for (int g = 0; g < NB_FACES; g++) begin
                c_cnt[c] = c_cnt[c] + FACE_COUNT_W'(c_mask[c][g]);
            end
            c_idx[c] = tgt_idx + IDXE'(cell_dx(c) + WIDTH * cell_dy(c)
                                       + WIDTH * HEIGHT * cell_dz(c));
            if (c == 0) begin
                c_pres[c] = 1'b1;
            end else begin
                c_pres[c] = r_win[SLOT_W'(slot_of(cell_dy(c), cell_dz(c)))]
                                 [3'(cell_dx(c) + 2)];
            end
        end
        // place: neighbors first, target last; destroy: target first
        for (int p = 0; p < NB_CELLS; p++) begin
            if (r_act == ACT_PLACE) begin
                if (p == NB_CELLS - 1) begin
                    l_idx[p]  = c_idx[0][BLOCK_INDEX_W-1:0];
                    l_mask[p] = c_mask[0];
                    l_cnt[p]  = c_cnt[0];
                    l_pres[p] = c_pres[0];
                end else begin
                    l_idx[p]  = c_idx[p+1][BLOCK_INDEX_W-1:0];
                    l_mask[p] = c_mask[p+1];
                    l_cnt[p]  = c_cnt[p+1];
                    l_pres[p] = c_pres[p+1];
                end
            end else begin
                l_idx[p]  = c_idx[p][BLOCK_INDEX_W-1:0];
                l_mask[p] = c_mask[p];
                l_cnt[p]  = c_cnt[p];
                l_pres[p] = c_pres[p];
            end
        end
    end

    // ------------------------------------------------------------------
    // Emit control
    // ------------------------------------------------------------------
    logic emit_go;
    logic emit_last;
    logic emit_end;

    assign emit_last = (((r_present >> r_p) >> 1) == '0);
    assign emit_go   = (r_state == ST_EMIT) && r_present[r_p]
                    && (!r_ov || i_m_axis_tready);
    assign emit_end  = (emit_go && emit_last)
                    || ((r_state == ST_EMIT) && !r_present[r_p]
                        && (r_p == CELL_W'(NB_CELLS - 1)));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == RAW'(ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_axis_tvalid && s_in_chunk) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (r_k == SLOT_W'(NB_SLOTS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_s_axis_tready = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = rd_row;
        ram_we          = 1'b0;
        ram_waddr       = r_row;
        ram_wdata       = wb_row;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            ST_LOAD: begin
                ram_re = 1'b1;
            end
            default: begin
            end
        endcase
        // target row returns first: write it back with the edited bit
        if (r_rd_vld && r_rd_slot == '0) begin
            ram_we = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_k      <= '0;
            r_rd_vld <= 1'b0;
            r_p      <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + RAW'(1);
            end
            if (r_state == ST_LOAD) begin
                r_k <= r_k + SLOT_W'(1);
            end else begin
                r_k <= '0;
            end
            r_rd_vld <= (r_state == ST_LOAD);
            if (r_state == ST_EMIT) begin
                if (!r_present[r_p] || emit_go) begin
                    r_p <= r_p + CELL_W'(1);
                end
            end else begin
                r_p <= '0;
            end
            if (emit_go) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_s_axis_tvalid) begin
            r_act <= i_s_axis_tuser;
            r_x   <= s_px - POS_X_W'(1);
            r_y   <= s_py - POS_Y_W'(1);
            r_z   <= s_pz - POS_Z_W'(1);
            r_row <= RAW'(s_py - POS_Y_W'(1))
                   + RAW'(HEIGHT) * RAW'(s_pz - POS_Z_W'(1));
        end
        r_rd_slot <= r_k;
        r_rd_inr  <= rd_inr;
        if (r_rd_vld) begin
            if (r_rd_inr) begin
                r_win[r_rd_slot] <= rd_wide[r_x +: SLICE_W];
            end else begin
                r_win[r_rd_slot] <= '0;
            end
        end
        if (r_state == ST_CALC) begin
            r_present <= l_pres;
            for (int p = 0; p < NB_CELLS; p++) begin
                r_lidx[p]  <= l_idx[p];
                r_lmask[p] <= l_mask[p];
                r_lcnt[p]  <= l_cnt[p];
            end
        end
        if (emit_go) begin
            r_o_idx  <= r_lidx[r_p];
            r_o_mask <= r_lmask[r_p];
            r_o_cnt  <= r_lcnt[r_p];
            r_o_last <= emit_last;
        end
    end

    // ------------------------------------------------------------------
    // Result stream
    // ------------------------------------------------------------------
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tdata  = {
        (M_TDATA_W - BLOCK_INDEX_W - FACE_MASK_W - FACE_COUNT_W)'(0),
        r_o_cnt, r_o_mask, r_o_idx
    };

endmodule

// ===== rtl/core/vfc_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vfc_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module vfc_ram #(
    parameter int DW    = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
